// File: sv/jse_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jse_pkg;

  localparam int MaxChars = 8;
  localparam int BodyChars = 6;
  localparam int CntW = $clog2(MaxChars + 1);
  localparam int IdxW = $clog2(MaxChars);
  localparam int BodyW = $clog2(BodyChars + 1);

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CtrlLimit  = 8'h20;
  localparam logic [7:0] HighStart  = 8'h7F;
  localparam logic [7:0] HexAlphaBase = 8'h57;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PLAIN,
    ESC_PAIR,
    ESC_HEX
  } esc_class_e;

  typedef struct packed {
    logic [7:0] data;
    logic       starts;
    logic       ends;
    esc_class_e cls;
    logic [7:0] pair_char;
  } cls_word_t;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntW-1:0]          count;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? CharZero : HexAlphaBase;
    return {4'b0000, nib} + base;
  endfunction

endpackage

// File: sv/jse_classify.sv
// Classify stage: decide the escape form of each input byte and register it.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_classify import jse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic      starts_string_i,
  input  logic      ends_string_i,
  input  logic      no_data_i,
  output logic      cls_valid_o,
  input  logic      cls_stall_i,
  output cls_word_t cls_word_o
);

  logic      valid_q;
  cls_word_t word_q, word_d;
  logic      load;

  assign in_stall_o = valid_q && cls_stall_i;
  assign load = !in_stall_o;

  always_comb begin
    word_d.data = data_byte_i;
    word_d.starts = starts_string_i;
    word_d.ends = ends_string_i;
    word_d.pair_char = data_byte_i;
    if (no_data_i) begin
      word_d.cls = ESC_NONE;
    end else if (data_byte_i == CharQuote || data_byte_i == CharBslash) begin
      word_d.cls = ESC_PAIR;
    end else if (data_byte_i == CharLf) begin
      word_d.cls = ESC_PAIR;
      word_d.pair_char = CharN;
    end else if (data_byte_i == CharCr) begin
      word_d.cls = ESC_PAIR;
      word_d.pair_char = CharR;
    end else if (data_byte_i == CharTab) begin
      word_d.cls = ESC_PAIR;
      word_d.pair_char = CharT;
    end else if (data_byte_i < CtrlLimit || data_byte_i >= HighStart) begin
      word_d.cls = ESC_HEX;
    end else begin
      word_d.cls = ESC_PLAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_word_o = word_q;

endmodule

// File: sv/jse_expand.sv
// Expand stage: lay out the quotes and escape sequence of one word as a run of characters.
// Depends on jse_pkg; fed by jse_classify.
`timescale 1ns / 1ps

module jse_expand import jse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cls_valid_i,
  output logic      cls_stall_o,
  input  cls_word_t cls_word_i,
  output logic      run_valid_o,
  input  logic      run_stall_i,
  output run_t      run_o
);

  logic valid_q;
  run_t run_q, run_d;
  logic load;

  assign cls_stall_o = valid_q && run_stall_i;
  assign load = !cls_stall_o;

  always_comb begin
    logic [BodyChars-1:0][7:0] body;
    logic [BodyW-1:0]          blen;
    logic [IdxW-1:0]           pos;
    body = {BodyChars{CharBslash}};
    blen = '0;
    unique case (cls_word_i.cls)
      ESC_NONE: begin
        blen = BodyW'(0);
      end
      ESC_PLAIN: begin
        body[0] = cls_word_i.data;
        blen = BodyW'(1);
      end
      ESC_PAIR: begin
        body[1] = cls_word_i.pair_char;
        blen = BodyW'(2);
      end
      ESC_HEX: begin
        body[1] = CharU;
        body[2] = CharZero;
        body[3] = CharZero;
        body[4] = hex_digit(cls_word_i.data[7:4]);
        body[5] = hex_digit(cls_word_i.data[3:0]);
        blen = BodyW'(BodyChars);
      end
      default: begin
        blen = '0;
      end
    endcase
    for (int i = 0; i < MaxChars; i++) begin
      pos = IdxW'(i) - IdxW'(cls_word_i.starts);
      if (cls_word_i.starts && i == 0) begin
        run_d.chars[i] = CharQuote;
      end else if ({1'b0, pos} < CntW'(blen)) begin
        run_d.chars[i] = body[pos];
      end else begin
        run_d.chars[i] = CharQuote;
      end
    end
    run_d.count = CntW'(cls_word_i.starts) + CntW'(blen) + CntW'(cls_word_i.ends);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= cls_valid_i && (run_d.count != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && cls_valid_i) begin
      run_q <= run_d;
    end
  end

  assign run_valid_o = valid_q;
  assign run_o = run_q;

endmodule

// File: sv/jse_serialise.sv
// Serialiser: hold one run; send one char per cycle unless stalled, via an output register.
// Depends on jse_pkg; fed by jse_expand.
`timescale 1ns / 1ps

module jse_serialise import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       run_valid_i,
  output logic       run_stall_o,
  input  run_t       run_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  logic            buf_valid_q, buf_valid_d;
  run_t            buf_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            out_free, emit, is_last, buf_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit = buf_valid_q && out_free;
  assign is_last = (({1'b0, idx_q}) + CntW'(1)) == buf_q.count;
  assign buf_take = !buf_valid_q || (emit && is_last);
  assign run_stall_o = !buf_take;

  always_comb begin
    buf_valid_d = buf_valid_q;
    idx_d = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d = is_last ? '0 : idx_q + IdxW'(1);
    end
    if (buf_take) begin
      buf_valid_d = run_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_take && run_valid_i) begin
      buf_q <= run_i;
    end
    if (emit) begin
      out_char_q <= buf_q.chars[idx_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o = out_char_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (buf_q.count != '0) && ({1'b0, idx_q} < buf_q.count))
    else $error("run index outside run");

  a_run_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !is_last |=> buf_valid_q && (idx_q == $past(idx_q) + IdxW'(1)))
    else $error("run dropped before its last character");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !buf_valid_q |-> idx_q == '0)
    else $error("index not cleared between runs");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && (last_of_run_o == $past(is_last)))
    else $error("emitted character missing at output");
`endif

endmodule

// File: sv/json_string_escaper.sv
// Top level of the JSON string escaper: classify, expand and serialise stages.
// Depends on jse_pkg, jse_classify, jse_expand and jse_serialise.
`timescale 1ns / 1ps

// Escapes raw string bytes into JSON string characters, one input word per byte
// with start and end flags that add the enclosing quotes. Each word becomes 0 to 8
// output characters; last_of_run_o marks the final character of each word, and a
// word with no_data set and no flags yields nothing. The output runs at one
// character per cycle unless out_stall_i holds it; an input word is taken every cycle
// while the output is not stalled and each word expands to at most one character;
// otherwise a longer word occupies the serialiser until its last character is sent,
// and stall is raised back up the pipe meanwhile. Each word passes through the
// classify, expand and run buffer registers, then the output register.
// Stateless between words; no configuration.

module json_string_escaper import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       starts_string_i,
  input  logic       ends_string_i,
  input  logic       no_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  logic      cls_valid, cls_stall;
  cls_word_t cls_word;
  logic      run_valid, run_stall;
  run_t      run;

  jse_classify u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .starts_string_i (starts_string_i),
    .ends_string_i   (ends_string_i),
    .no_data_i       (no_data_i),
    .cls_valid_o     (cls_valid),
    .cls_stall_i     (cls_stall),
    .cls_word_o      (cls_word)
  );

  jse_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_stall_o (cls_stall),
    .cls_word_i  (cls_word),
    .run_valid_o (run_valid),
    .run_stall_i (run_stall),
    .run_o       (run)
  );

  jse_serialise u_serialise (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_valid_i   (run_valid),
    .run_stall_o   (run_stall),
    .run_i         (run),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: tb/tb_json_string_escaper.sv
// Self-checking bench for json_string_escaper: random and directed byte streams with
// start/end/no-data flags, random idling on both channels. Depends on jse_pkg and the RTL.
`timescale 1ns / 1ps

module tb_json_string_escaper;
  import jse_pkg::*;

  localparam logic [7:0] CharLowerA = 8'h61;
  localparam int RandomWords = 230;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  class json_escape_sb;
    esc_char_t expected_chars[$];
    logic [7:0] run_chars[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return CharLowerA + {4'h0, nib} - 8'd10;
    endfunction

    function void put_char(logic [7:0] c);
      run_chars.insert(run_chars.size(), c);
    endfunction

    function void note_word(logic [7:0] b, logic s, logic e, logic nd);
      esc_char_t item;
      run_chars.delete();
      if (s) put_char(CharQuote);
      if (!nd) begin
        case (b)
          CharQuote, CharBslash: begin
            put_char(CharBslash);
            put_char(b);
          end
          CharLf: begin
            put_char(CharBslash);
            put_char(CharN);
          end
          CharCr: begin
            put_char(CharBslash);
            put_char(CharR);
          end
          CharTab: begin
            put_char(CharBslash);
            put_char(CharT);
          end
          default: begin
            if (b < CtrlLimit || b >= HighStart) begin
              put_char(CharBslash);
              put_char(CharU);
              put_char(CharZero);
              put_char(CharZero);
              put_char(hex_char(b[7:4]));
              put_char(hex_char(b[3:0]));
            end else begin
              put_char(b);
            end
          end
        endcase
      end
      if (e) put_char(CharQuote);
      foreach (run_chars[i]) begin
        item.ch = run_chars[i];
        item.last = (i == run_chars.size() - 1);
        expected_chars.insert(expected_chars.size(), item);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      esc_char_t want;
      if (expected_chars.size() == 0) begin
        $error("out_char: expected none, got %h", ch);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        $error("out_char: expected %h, got %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       starts_string_i = 1'b0;
  logic       ends_string_i = 1'b0;
  logic       no_data_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic       last_of_run_o;

  json_escape_sb sb;
  bit drive_burst = 1'b0;
  bit drain_burst = 1'b0;
  int cycle_count = 0;

  json_string_escaper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .starts_string_i (starts_string_i),
    .ends_string_i   (ends_string_i),
    .no_data_i       (no_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("json_string_escaper: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_word(data_byte_i, starts_string_i, ends_string_i, no_data_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_char(out_char_o, last_of_run_o);
  end

  task automatic send_word(input logic [7:0] b, input logic s, input logic e,
                           input logic nd);
    int gap;
    gap = drive_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    starts_string_i <= s;
    ends_string_i <= e;
    no_data_i <= nd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_chars();
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) drain_burst = ~drain_burst;
      gap = drain_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return CharQuote;
          1: return CharBslash;
          2: return CharLf;
          3: return CharCr;
          default: return CharTab;
        endcase
      end
      1: return 8'($urandom_range(0, 31));
      2: return 8'($urandom_range(127, 255));
      3: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_chars();
    join_none
  end

  initial begin
    int sent;
    int len;
    logic [7:0] b;
    logic s;
    logic e;
    logic nd;
    bit drop_start;
    bit drop_end;

    sb = new();
    repeat (5) @(posedge clk_i);

    send_word(8'h41, 1'b1, 1'b0, 1'b0);
    send_word(CharQuote, 1'b0, 1'b0, 1'b0);
    send_word(CharBslash, 1'b0, 1'b0, 1'b0);
    send_word(CharLf, 1'b0, 1'b0, 1'b0);
    send_word(CharCr, 1'b0, 1'b0, 1'b0);
    send_word(CharTab, 1'b0, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0, 1'b0);
    send_word(8'h1F, 1'b0, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0, 1'b0);
    send_word(8'h7E, 1'b0, 1'b0, 1'b0);
    send_word(8'h7F, 1'b0, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0, 1'b1);
    send_word(8'h5A, 1'b1, 1'b0, 1'b1);
    send_word(8'hA5, 1'b0, 1'b1, 1'b1);
    send_word(8'h9B, 1'b1, 1'b1, 1'b0);
    send_word(CharQuote, 1'b1, 1'b1, 1'b0);
    send_word(8'h08, 1'b0, 1'b1, 1'b0);
    send_word(8'h61, 1'b1, 1'b0, 1'b0);

    sent = 0;
    while (sent < RandomWords) begin
      if ($urandom_range(0, 3) == 0) drive_burst = ~drive_burst;
      if ($urandom_range(0, 9) == 0) begin
        b = 8'($urandom_range(0, 255));
        s = 1'($urandom_range(0, 1));
        e = 1'($urandom_range(0, 1));
        nd = 1'($urandom_range(0, 1));
        send_word(b, s, e, nd);
        if (!(nd && !s && !e)) sent++;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
        drop_start = ($urandom_range(0, 11) == 0);
        drop_end = ($urandom_range(0, 11) == 0);
        if (len == 0) begin
          send_word(8'($urandom_range(0, 255)), !drop_start, !drop_end, 1'b1);
          if (!(drop_start && drop_end)) sent++;
        end else begin
          for (int i = 0; i < len; i++) begin
            send_word(pick_byte(), (i == 0) && !drop_start, (i == len - 1) && !drop_end,
                      1'b0);
            sent++;
          end
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("json_string_escaper: match");
    end else begin
      $display("json_string_escaper: mismatch");
    end
    $finish;
  end

endmodule

// File: json_string_escaper.f
sv/jse_pkg.sv
sv/jse_classify.sv
sv/jse_expand.sv
sv/jse_serialise.sv
sv/json_string_escaper.sv
tb/tb_json_string_escaper.sv
